/* rtl/core/ptt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, codes and reset values of the push-to-talk controller.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int unsigned CMD_W   = 4;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned REG_W   = 2;

    typedef logic [TIME_W-1:0] time_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_READY      = 4'd0,
        CMD_PRESS      = 4'd1,
        CMD_WAKE_PRESS = 4'd2,
        CMD_RELEASE    = 4'd3,
        CMD_TICK       = 4'd4,
        CMD_TRANSCRIPT = 4'd5,
        CMD_TOOL       = 4'd6,
        CMD_SPEECH     = 4'd7,
        CMD_FINISHED   = 4'd8,
        CMD_ACTIVITY   = 4'd9,
        CMD_FAIL       = 4'd10,
        CMD_SLEEP      = 4'd11
    } cmd_t;

    typedef enum logic [8:0] {
        MODE_BOOT  = 9'b000000001,
        MODE_IDLE  = 9'b000000010,
        MODE_REC   = 9'b000000100,
        MODE_TRANS = 9'b000001000,
        MODE_THINK = 9'b000010000,
        MODE_TOOL  = 9'b000100000,
        MODE_SPEAK = 9'b001000000,
        MODE_ERR   = 9'b010000000,
        MODE_SLEEP = 9'b100000000
    } mode_t;

    localparam logic [CODE_W-1:0] CODE_BOOT  = 4'd0;
    localparam logic [CODE_W-1:0] CODE_IDLE  = 4'd1;
    localparam logic [CODE_W-1:0] CODE_REC   = 4'd2;
    localparam logic [CODE_W-1:0] CODE_TRANS = 4'd3;
    localparam logic [CODE_W-1:0] CODE_THINK = 4'd4;
    localparam logic [CODE_W-1:0] CODE_TOOL  = 4'd5;
    localparam logic [CODE_W-1:0] CODE_SPEAK = 4'd6;
    localparam logic [CODE_W-1:0] CODE_ERR   = 4'd7;
    localparam logic [CODE_W-1:0] CODE_SLEEP = 4'd8;

    typedef enum logic [REG_W-1:0] {
        REG_TALK_HOLD  = 2'd0,
        REG_IDLE_SLEEP = 2'd1,
        REG_ERROR_SHOW = 2'd2
    } reg_idx_t;

    localparam time_t TALK_HOLD_RST  = 32'd300;
    localparam time_t IDLE_SLEEP_RST = 32'd60000;
    localparam time_t ERROR_SHOW_RST = 32'd3000;

    typedef struct packed {
        time_t talk_hold_time;
        time_t idle_sleep_time;
        time_t error_show_time;
    } cfg_t;

    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        logic [CODE_W-1:0] c;
        case (m)
            MODE_BOOT:  c = CODE_BOOT;
            MODE_IDLE:  c = CODE_IDLE;
            MODE_REC:   c = CODE_REC;
            MODE_TRANS: c = CODE_TRANS;
            MODE_THINK: c = CODE_THINK;
            MODE_TOOL:  c = CODE_TOOL;
            MODE_SPEAK: c = CODE_SPEAK;
            MODE_ERR:   c = CODE_ERR;
            MODE_SLEEP: c = CODE_SLEEP;
            default:    c = CODE_BOOT;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/ptt_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_if
// Channel interfaces: event input, result output and register writes.
// ----------------------------------------------------------------------------
interface ptt_evt_if;
    logic                         valid;
    logic                         ready;
    logic [ptt_pkg::CMD_W-1:0]    cmd;
    ptt_pkg::time_t               now_time;

    modport source (output valid, output cmd, output now_time, input ready);
    modport sink   (input valid, input cmd, input now_time, output ready);
endinterface

interface ptt_res_if;
    logic                         valid;
    logic                         ready;
    logic [ptt_pkg::CODE_W-1:0]   state_code;
    logic                         button_held;
    ptt_pkg::time_t               inactivity_time;

    modport source (output valid, output state_code, output button_held,
                    output inactivity_time, input ready);
    modport sink   (input valid, input state_code, input button_held,
                    input inactivity_time, output ready);
endinterface

interface ptt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ptt_pkg::REG_W-1:0]    reg_index;
    ptt_pkg::time_t               wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface
`default_nettype wire

/* rtl/core/push_to_talk_interaction_fsm.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// push_to_talk_interaction_fsm
// Push-to-talk interaction controller: one result beat per event beat.
// ----------------------------------------------------------------------------
// Flow: an accepted event beat is held in the event register; once the
// result register is empty or being taken, its state update moves into it.
// Throughput: one event per cycle while the result side does not stall;
// state update runs from the event register into the result register.
// Reset: asynchronous, active low; state returns to booting, flags and
// timestamps clear, timeouts return to 300, 60000 and 3000 ms.
// ----------------------------------------------------------------------------
module push_to_talk_interaction_fsm (
    input  wire logic clk,
    input  wire logic rst_n,
    ptt_cfg_if.sink   cfg,
    ptt_evt_if.sink   evt,
    ptt_res_if.source res
);

    ptt_pkg::cfg_t cfg_q;

    ptt_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    ptt_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg_q (cfg_q),
        .evt   (evt),
        .res   (res)
    );

endmodule
`default_nettype wire

/* rtl/core/ptt_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_cfg_regs
// Timeout registers, written one beat at a time from the write channel.
// ----------------------------------------------------------------------------
module ptt_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ptt_cfg_if.sink      cfg,
    output ptt_pkg::cfg_t cfg_q
);

    ptt_pkg::cfg_t cfg_reg;
    ptt_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (ptt_pkg::reg_idx_t'(cfg.reg_index))
                ptt_pkg::REG_TALK_HOLD:  cfg_next.talk_hold_time  = cfg.wr_data;
                ptt_pkg::REG_IDLE_SLEEP: cfg_next.idle_sleep_time = cfg.wr_data;
                ptt_pkg::REG_ERROR_SHOW: cfg_next.error_show_time = cfg.wr_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.talk_hold_time  <= ptt_pkg::TALK_HOLD_RST;
            cfg_reg.idle_sleep_time <= ptt_pkg::IDLE_SLEEP_RST;
            cfg_reg.error_show_time <= ptt_pkg::ERROR_SHOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ptt_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_core
// Event register, state update and result register of the controller.
// ----------------------------------------------------------------------------
module ptt_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ptt_pkg::cfg_t cfg_q,
    ptt_evt_if.sink       evt,
    ptt_res_if.source     res
);

    logic                      in_valid_reg;
    logic [ptt_pkg::CMD_W-1:0] cmd_reg;
    ptt_pkg::time_t            time_reg;

    ptt_pkg::mode_t            mode_reg, mode_next;
    logic                      pressed_reg, pressed_next;
    logic                      wake_reg, wake_next;
    ptt_pkg::time_t            press_reg, press_next;
    ptt_pkg::time_t            activity_reg, activity_next;
    ptt_pkg::time_t            entry_reg, entry_next;

    logic                      out_valid_reg;
    logic [ptt_pkg::CODE_W-1:0] code_reg;
    logic                      held_reg;
    ptt_pkg::time_t            inact_reg;

    logic                      advance;
    ptt_pkg::time_t            since_press;
    ptt_pkg::time_t            since_activity;
    ptt_pkg::time_t            since_entry;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !in_valid_reg || advance;

    assign res.valid           = out_valid_reg;
    assign res.state_code      = code_reg;
    assign res.button_held     = held_reg;
    assign res.inactivity_time = inact_reg;

    assign since_press    = time_reg - press_reg;
    assign since_activity = time_reg - activity_reg;
    assign since_entry    = time_reg - entry_reg;

    always_comb
    begin
        mode_next     = mode_reg;
        pressed_next  = pressed_reg;
        wake_next     = wake_reg;
        press_next    = press_reg;
        activity_next = activity_reg;
        entry_next    = entry_reg;
        case (ptt_pkg::cmd_t'(cmd_reg))
            ptt_pkg::CMD_READY:
            begin
                pressed_next  = 1'b0;
                wake_next     = 1'b0;
                mode_next     = ptt_pkg::MODE_IDLE;
                entry_next    = time_reg;
                activity_next = time_reg;
            end
            ptt_pkg::CMD_PRESS:
            begin
                if (mode_reg != ptt_pkg::MODE_SLEEP && !pressed_reg)
                begin
                    if (mode_reg != ptt_pkg::MODE_IDLE)
                    begin
                        mode_next  = ptt_pkg::MODE_IDLE;
                        entry_next = time_reg;
                    end
                    pressed_next  = 1'b1;
                    wake_next     = 1'b0;
                    press_next    = time_reg;
                    activity_next = time_reg;
                end
            end
            ptt_pkg::CMD_WAKE_PRESS:
            begin
                if (mode_reg == ptt_pkg::MODE_IDLE && !pressed_reg)
                begin
                    pressed_next  = 1'b1;
                    wake_next     = 1'b1;
                    press_next    = time_reg;
                    activity_next = time_reg;
                end
            end
            ptt_pkg::CMD_RELEASE:
            begin
                if (pressed_reg)
                begin
                    pressed_next  = 1'b0;
                    wake_next     = 1'b0;
                    activity_next = time_reg;
                    if (mode_reg == ptt_pkg::MODE_REC)
                    begin
                        mode_next  = ptt_pkg::MODE_TRANS;
                        entry_next = time_reg;
                    end
                    else if (mode_reg == ptt_pkg::MODE_IDLE && !wake_reg)
                    begin
                        mode_next  = ptt_pkg::MODE_SLEEP;
                        entry_next = time_reg;
                    end
                end
            end
            ptt_pkg::CMD_TICK:
            begin
                if (mode_reg == ptt_pkg::MODE_IDLE && pressed_reg
                    && since_press >= cfg_q.talk_hold_time)
                begin
                    mode_next  = ptt_pkg::MODE_REC;
                    entry_next = time_reg;
                end
                else if (mode_reg == ptt_pkg::MODE_IDLE && !pressed_reg
                         && since_activity >= cfg_q.idle_sleep_time)
                begin
                    mode_next  = ptt_pkg::MODE_SLEEP;
                    entry_next = time_reg;
                end
                else if (mode_reg == ptt_pkg::MODE_ERR
                         && since_entry >= cfg_q.error_show_time)
                begin
                    mode_next     = ptt_pkg::MODE_IDLE;
                    entry_next    = time_reg;
                    activity_next = time_reg;
                end
            end
            ptt_pkg::CMD_TRANSCRIPT:
            begin
                if (mode_reg == ptt_pkg::MODE_TRANS)
                begin
                    mode_next  = ptt_pkg::MODE_THINK;
                    entry_next = time_reg;
                end
            end
            ptt_pkg::CMD_TOOL:
            begin
                if (mode_reg == ptt_pkg::MODE_THINK)
                begin
                    mode_next  = ptt_pkg::MODE_TOOL;
                    entry_next = time_reg;
                end
            end
            ptt_pkg::CMD_SPEECH:
            begin
                if (mode_reg inside {ptt_pkg::MODE_THINK, ptt_pkg::MODE_TOOL})
                begin
                    mode_next  = ptt_pkg::MODE_SPEAK;
                    entry_next = time_reg;
                end
            end
            ptt_pkg::CMD_FINISHED:
            begin
                if (mode_reg inside {ptt_pkg::MODE_TRANS, ptt_pkg::MODE_THINK,
                                     ptt_pkg::MODE_TOOL, ptt_pkg::MODE_SPEAK})
                begin
                    mode_next     = ptt_pkg::MODE_IDLE;
                    entry_next    = time_reg;
                    activity_next = time_reg;
                end
            end
            ptt_pkg::CMD_ACTIVITY:
            begin
                if (mode_reg == ptt_pkg::MODE_IDLE && !pressed_reg)
                begin
                    activity_next = time_reg;
                end
            end
            ptt_pkg::CMD_FAIL:
            begin
                if (mode_reg != ptt_pkg::MODE_SLEEP)
                begin
                    pressed_next = 1'b0;
                    wake_next    = 1'b0;
                    mode_next    = ptt_pkg::MODE_ERR;
                    entry_next   = time_reg;
                end
            end
            ptt_pkg::CMD_SLEEP:
            begin
                pressed_next = 1'b0;
                wake_next    = 1'b0;
                mode_next    = ptt_pkg::MODE_SLEEP;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= ptt_pkg::MODE_BOOT;
            pressed_reg   <= 1'b0;
            wake_reg      <= 1'b0;
            press_reg     <= '0;
            activity_reg  <= '0;
            entry_reg     <= '0;
        end
        else
        begin
            if (evt.ready)
            begin
                in_valid_reg <= evt.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                pressed_reg   <= pressed_next;
                wake_reg      <= wake_next;
                press_reg     <= press_next;
                activity_reg  <= activity_next;
                entry_reg     <= entry_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            cmd_reg  <= evt.cmd;
            time_reg <= evt.now_time;
        end
        if (advance)
        begin
            code_reg  <= ptt_pkg::mode_code(mode_next);
            held_reg  <= pressed_next;
            inact_reg <= time_reg - activity_next;
        end
    end

endmodule
`default_nettype wire

/* verif/ptt_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptt_result_checker
// Watches the register, event and result channels of the push-to-talk
// controller. It predicts the state code, button flag and inactivity time
// for every accepted event beat. Each result beat is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module ptt_result_checker (
    input  logic       clk,
    input  logic       rst_n,
    ptt_cfg_if         cfg,
    ptt_evt_if         evt,
    ptt_res_if         res,
    output int         fail_count = 0,
    output int         pending = 0,
    output int         events_seen = 0,
    output int         results_seen = 0,
    output int         writes_seen = 0,
    output logic [8:0] modes_seen = '0
);
    import ptt_pkg::*;

    localparam int unsigned MAX_PRINTED = 30;

    typedef struct packed {
        logic [CODE_W-1:0] state_code;
        logic              button_held;
        time_t             inactivity_time;
    } ptt_result_t;

    typedef struct {
        logic [CODE_W-1:0] mode;
        logic              held;
        logic              wake;
        time_t             press_at;
        time_t             active_at;
        time_t             entered_at;
    } ctl_state_t;

    ctl_state_t  ctl;
    cfg_t        timeouts;
    ptt_result_t expected_results[$];

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED)
        begin
            $display("[%0t] MISMATCH at result %0d: %s", $time, results_seen, msg);
        end
        fail_count++;
    endtask

    function automatic void enter_mode(input logic [CODE_W-1:0] next, input time_t t);
        ctl.mode = next;
        ctl.entered_at = t;
    endfunction

    function automatic void advance_controller(input logic [CMD_W-1:0] code, input time_t t);
        logic  was_wake;
        time_t held_for;
        time_t quiet_for;
        time_t shown_for;
        was_wake  = ctl.wake;
        held_for  = t - ctl.press_at;
        quiet_for = t - ctl.active_at;
        shown_for = t - ctl.entered_at;
        case (code)
            CMD_READY:
            begin
                ctl.held = 1'b0;
                ctl.wake = 1'b0;
                enter_mode(CODE_IDLE, t);
                ctl.active_at = t;
            end
            CMD_PRESS:
            begin
                if (ctl.mode != CODE_SLEEP && !ctl.held)
                begin
                    if (ctl.mode != CODE_IDLE)
                        enter_mode(CODE_IDLE, t);
                    ctl.held = 1'b1;
                    ctl.wake = 1'b0;
                    ctl.press_at = t;
                    ctl.active_at = t;
                end
            end
            CMD_WAKE_PRESS:
            begin
                if (ctl.mode == CODE_IDLE && !ctl.held)
                begin
                    ctl.held = 1'b1;
                    ctl.wake = 1'b1;
                    ctl.press_at = t;
                    ctl.active_at = t;
                end
            end
            CMD_RELEASE:
            begin
                if (ctl.held)
                begin
                    ctl.held = 1'b0;
                    ctl.wake = 1'b0;
                    ctl.active_at = t;
                    if (ctl.mode == CODE_REC)
                        enter_mode(CODE_TRANS, t);
                    else if (ctl.mode == CODE_IDLE && !was_wake)
                        enter_mode(CODE_SLEEP, t);
                end
            end
            CMD_TICK:
            begin
                if (ctl.mode == CODE_IDLE && ctl.held && held_for >= timeouts.talk_hold_time)
                begin
                    enter_mode(CODE_REC, t);
                end
                else if (ctl.mode == CODE_IDLE && !ctl.held &&
                         quiet_for >= timeouts.idle_sleep_time)
                begin
                    enter_mode(CODE_SLEEP, t);
                end
                else if (ctl.mode == CODE_ERR && shown_for >= timeouts.error_show_time)
                begin
                    enter_mode(CODE_IDLE, t);
                    ctl.active_at = t;
                end
            end
            CMD_TRANSCRIPT:
            begin
                if (ctl.mode == CODE_TRANS)
                    enter_mode(CODE_THINK, t);
            end
            CMD_TOOL:
            begin
                if (ctl.mode == CODE_THINK)
                    enter_mode(CODE_TOOL, t);
            end
            CMD_SPEECH:
            begin
                if (ctl.mode == CODE_THINK || ctl.mode == CODE_TOOL)
                    enter_mode(CODE_SPEAK, t);
            end
            CMD_FINISHED:
            begin
                if (ctl.mode == CODE_TRANS || ctl.mode == CODE_THINK ||
                    ctl.mode == CODE_TOOL || ctl.mode == CODE_SPEAK)
                begin
                    enter_mode(CODE_IDLE, t);
                    ctl.active_at = t;
                end
            end
            CMD_ACTIVITY:
            begin
                if (ctl.mode == CODE_IDLE && !ctl.held)
                    ctl.active_at = t;
            end
            CMD_FAIL:
            begin
                if (ctl.mode != CODE_SLEEP)
                begin
                    ctl.held = 1'b0;
                    ctl.wake = 1'b0;
                    enter_mode(CODE_ERR, t);
                end
            end
            CMD_SLEEP:
            begin
                // keep the entry time as it is
                ctl.held = 1'b0;
                ctl.wake = 1'b0;
                ctl.mode = CODE_SLEEP;
            end
            default: ;
        endcase
    endfunction

    task automatic check_result();
        ptt_result_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result beat with no event pending");
            return;
        end
        want = expected_results.pop_front();
        if (res.state_code !== want.state_code)
            report_mismatch($sformatf("state_code got %0d want %0d",
                                      res.state_code, want.state_code));
        if (res.button_held !== want.button_held)
            report_mismatch($sformatf("button_held got %0b want %0b",
                                      res.button_held, want.button_held));
        if (res.inactivity_time !== want.inactivity_time)
            report_mismatch($sformatf("inactivity_time got %0d want %0d",
                                      res.inactivity_time, want.inactivity_time));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl.mode       = CODE_BOOT;
            ctl.held       = 1'b0;
            ctl.wake       = 1'b0;
            ctl.press_at   = '0;
            ctl.active_at  = '0;
            ctl.entered_at = '0;
            timeouts.talk_hold_time  = TALK_HOLD_RST;
            timeouts.idle_sleep_time = IDLE_SLEEP_RST;
            timeouts.error_show_time = ERROR_SHOW_RST;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (res.valid && res.ready)
                check_result();
            if (evt.valid && evt.ready)
            begin
                advance_controller(evt.cmd, evt.now_time);
                expected_results.push_back('{ctl.mode, ctl.held, evt.now_time - ctl.active_at});
                modes_seen[ctl.mode] = 1'b1;
                events_seen++;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    REG_TALK_HOLD:  timeouts.talk_hold_time  = cfg.wr_data;
                    REG_IDLE_SLEEP: timeouts.idle_sleep_time = cfg.wr_data;
                    REG_ERROR_SHOW: timeouts.error_show_time = cfg.wr_data;
                    default: ;
                endcase
                writes_seen++;
            end
            pending = expected_results.size();
        end
    end

endmodule

/* verif/tb_push_to_talk_interaction_fsm.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_push_to_talk_interaction_fsm
// Drives the push-to-talk controller with a directed walk through every
// state and timeout, then with random talk sessions and noise under several
// timeout settings. Events come in bursts with random gaps and the result
// side stalls on patterns that change over time. Checking is done by
// ptt_result_checker beside the block.
// ----------------------------------------------------------------------------
module tb_push_to_talk_interaction_fsm;
    import ptt_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned ITEMS_PER_PHASE = 200;
    localparam logic [REG_W-1:0] REG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    ptt_cfg_if cfg_ch ();
    ptt_evt_if evt_ch ();
    ptt_res_if res_ch ();

    int         fail_count;
    int         pending;
    int         events_seen;
    int         results_seen;
    int         writes_seen;
    logic [8:0] modes_seen;

    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    int unsigned sent_events = 0;
    int unsigned settings_run = 1;
    time_t       clock_ms = '0;

    int unsigned stall_mode = 0;
    int unsigned stall_span = 0;
    logic [7:0]  stall_mask = 8'hff;

    push_to_talk_interaction_fsm uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .evt   (evt_ch),
        .res   (res_ch)
    );

    ptt_result_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_ch),
        .evt          (evt_ch),
        .res          (res_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .events_seen  (events_seen),
        .results_seen (results_seen),
        .writes_seen  (writes_seen),
        .modes_seen   (modes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("Simulation FAILED");
        $finish;
    end

    // result side: hold ready on a random pattern that is redrawn after a random span
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(16, 96);
            stall_mask = $urandom() | 8'h01;
        end
        stall_span--;
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 3) != 0);
            2: res_ch.ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                res_ch.ready <= stall_mask[0];
                stall_mask = {stall_mask[0], stall_mask[7:1]};
            end
        endcase
    end

    function automatic time_t next_stamp();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            clock_ms += $urandom_range(0, 120);
        else if (pick < 75)
            clock_ms += $urandom_range(100, 4000);
        else if (pick < 87)
            clock_ms += $urandom_range(4000, 90000);
        else if (pick < 93)
            clock_ms = $urandom();
        else
            clock_ms -= $urandom_range(1, 50);
        return clock_ms;
    endfunction

    task automatic send_event(input logic [CMD_W-1:0] code, input time_t stamp);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                evt_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        evt_ch.valid    <= 1'b1;
        evt_ch.cmd      <= code;
        evt_ch.now_time <= stamp;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        burst_left--;
        sent_events++;
    endtask

    task automatic write_reg(input logic [REG_W-1:0] index, input time_t value);
        @(negedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= index;
        cfg_ch.wr_data   <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        evt_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic run_directed();
        // boot, unused code, wrap of the press timer across zero
        send_event(CMD_TICK, 32'd0);
        send_event(4'd15, 32'd5);
        send_event(CMD_READY, 32'hffff_ff00);
        send_event(CMD_PRESS, 32'hffff_ff80);
        send_event(CMD_PRESS, 32'hffff_ff90);
        send_event(CMD_TICK, 32'h0000_00ab);
        send_event(CMD_TICK, 32'h0000_00ac);
        // full turn through every busy state
        send_event(CMD_RELEASE, 32'd256);
        send_event(CMD_TRANSCRIPT, 32'd266);
        send_event(CMD_TOOL, 32'd276);
        send_event(CMD_SPEECH, 32'd286);
        send_event(CMD_FINISHED, 32'd296);
        // wake press stays idle, plain press release goes to sleep, which ignores press and fail
        send_event(CMD_WAKE_PRESS, 32'd306);
        send_event(CMD_RELEASE, 32'd316);
        send_event(CMD_PRESS, 32'd326);
        send_event(CMD_RELEASE, 32'd336);
        send_event(CMD_PRESS, 32'd346);
        send_event(CMD_FAIL, 32'd356);
        // idle timeout on the exact boundary
        send_event(CMD_READY, 32'd366);
        send_event(CMD_ACTIVITY, 32'd376);
        send_event(CMD_TICK, 32'd60375);
        send_event(CMD_TICK, 32'd60376);
        // error timeout on the exact boundary, then sleep and a backwards stamp
        send_event(CMD_READY, 32'd60400);
        send_event(CMD_FAIL, 32'd60500);
        send_event(CMD_TICK, 32'd63499);
        send_event(CMD_TICK, 32'd63500);
        send_event(CMD_SLEEP, 32'd63600);
        send_event(CMD_TICK, 32'd12);
        clock_ms = 32'd12;
    endtask

    task automatic run_session();
        if ($urandom_range(0, 9) < 4)
            send_event(CMD_READY, next_stamp());
        if ($urandom_range(0, 4) == 0)
            send_event(CMD_ACTIVITY, next_stamp());
        send_event(($urandom_range(0, 3) == 0) ? CMD_WAKE_PRESS : CMD_PRESS, next_stamp());
        repeat ($urandom_range(0, 4)) send_event(CMD_TICK, next_stamp());
        send_event(CMD_RELEASE, next_stamp());
        if ($urandom_range(0, 9) == 0)
            send_event(CMD_FAIL, next_stamp());
        send_event(CMD_TRANSCRIPT, next_stamp());
        if ($urandom_range(0, 2) == 0)
            send_event(CMD_TOOL, next_stamp());
        send_event(CMD_SPEECH, next_stamp());
        if ($urandom_range(0, 7) == 0)
            send_event(CMD_FAIL, next_stamp());
        else if ($urandom_range(0, 11) == 0)
            send_event(CMD_SLEEP, next_stamp());
        send_event(CMD_FINISHED, next_stamp());
        repeat ($urandom_range(0, 3)) send_event(CMD_TICK, next_stamp());
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned stop_at;
        stop_at = sent_events + count;
        while (sent_events < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
                run_session();
            else
                repeat ($urandom_range(1, 5)) send_event($urandom_range(0, 15), next_stamp());
        end
    endtask

    task automatic set_timeouts(input time_t hold, input time_t quiet, input time_t shown);
        drain();
        write_reg(REG_TALK_HOLD, hold);
        write_reg(REG_IDLE_SLEEP, quiet);
        write_reg(REG_ERROR_SHOW, shown);
        settings_run++;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        evt_ch.valid       = 1'b0;
        evt_ch.cmd         = CMD_READY;
        evt_ch.now_time    = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = REG_TALK_HOLD;
        cfg_ch.wr_data     = '0;
        res_ch.ready       = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(ITEMS_PER_PHASE);

        set_timeouts('0, '0, '0);
        run_random(ITEMS_PER_PHASE);

        set_timeouts('1, '1, '1);
        write_reg(REG_UNUSED, $urandom());
        run_random(ITEMS_PER_PHASE - 50);

        set_timeouts($urandom_range(0, 400), $urandom_range(0, 3000), $urandom_range(0, 2000));
        run_random(ITEMS_PER_PHASE + 50);

        set_timeouts($urandom(), $urandom(), $urandom());
        run_random(ITEMS_PER_PHASE);

        drain();
        repeat (8) @(negedge clk);

        $display("Sent %0d events, checked %0d results, %0d register writes, %0d timeout settings",
                 events_seen, results_seen, writes_seen, settings_run);
        $display("Controller states reached (bit n = state code n): %09b", modes_seen);
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
